/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked on clk_i, disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset
`define DTPW_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Expression must never be true out of reset
`define DTPW_NEVER(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

/* design/dtpw_pkg.sv */
// ---------------------------------------------------------------------------
// dtpw_pkg
// Types and constants shared by the depth test and pixel write block.
// ---------------------------------------------------------------------------
package dtpw_pkg;

  // Command codes of the fragment channel
  typedef enum logic [1:0] {
    OP_FRAGMENT    = 2'd0,
    OP_CLEAR_DEPTH = 2'd1,
    OP_CLEAR_COLOR = 2'd2,
    OP_READ        = 2'd3
  } dtpw_op_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_CLR_DEPTH,
    ST_CLR_COLOR,
    ST_PUSH
  } dtpw_state_e;

  // Register map (index taken from paddr[2])
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned FRAME_W    = 9;
  // Wide enough for the largest store dimension and for a 9-bit frame size
  localparam int unsigned DIM_W      = 13;

  // Most negative Q16.16 value, stands for negative infinity
  localparam logic [31:0] DEPTH_NEG_INF = 32'h8000_0000;

  typedef struct packed {
    dtpw_op_e           cmd;
    logic [7:0]         pos_x;
    logic [7:0]         pos_y;
    logic signed [31:0] frag_depth;
    logic [31:0]        color_in;
  } dtpw_frag_t;

  typedef struct packed {
    logic        passed;
    logic [31:0] pixel_color;
    logic        status;
  } dtpw_res_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic rd_en;
    logic check;
    logic fill_depth;
    logic fill_color;
    logic fill_init;
    logic push;
  } dtpw_ctl_t;

  // Datapath to controller
  typedef struct packed {
    dtpw_op_e op;
    logic     in_frame;
    logic     sweep_last;
    logic     out_free;
  } dtpw_sts_t;

endpackage

/* design/dtpw_in_if.sv */
// ---------------------------------------------------------------------------
// dtpw_in_if
// Fragment command channel: valid/ready handshake with command payload.
// ---------------------------------------------------------------------------
interface dtpw_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [7:0]         pos_x;
  logic [7:0]         pos_y;
  logic signed [31:0] frag_depth;
  logic [31:0]        color_in;

  modport source (
    output valid, cmd, pos_x, pos_y, frag_depth, color_in,
    input  ready
  );

  modport sink (
    input  valid, cmd, pos_x, pos_y, frag_depth, color_in,
    output ready
  );
endinterface

/* design/dtpw_out_if.sv */
// ---------------------------------------------------------------------------
// dtpw_out_if
// Result channel: valid/ready handshake with one result per command.
// ---------------------------------------------------------------------------
interface dtpw_out_if;
  logic        valid;
  logic        ready;
  logic        passed;
  logic [31:0] pixel_color;
  logic        status;

  modport source (
    output valid, passed, pixel_color, status,
    input  ready
  );

  modport sink (
    input  valid, passed, pixel_color, status,
    output ready
  );
endinterface

/* design/depth_test_pixel_write_core.sv */
// ---------------------------------------------------------------------------
// depth_test_pixel_write_core
// Z-buffer back end: greater-or-equal depth test, pixel write, clears, reads.
//
//   channel   dir  handshake           payload
//   frag_i    in   valid/ready         cmd, pos_x, pos_y, frag_depth, color_in
//   res_o     out  valid/ready         passed, pixel_color, status
//   apb       in   psel/penable/pwrite frame_width (0x0), frame_height (0x4)
//
// Fragment and read: accept, store read, check/write and result push; a
// rejected position goes from accept straight to result push.
// Clears: accept, a sweep with one store entry written a cycle, result push.
// After reset both stores are swept with frag_i.ready low; configuration
// writes are taken throughout.
// A stalled result holds in the output register; the next command is taken
// meanwhile and waits at its push.
// ---------------------------------------------------------------------------
module depth_test_pixel_write_core #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned COLOR_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  dtpw_in_if.sink                           frag_i,
  dtpw_out_if.source                        res_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dtpw_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  logic [dtpw_pkg::FRAME_W-1:0] width_q, height_q;
  logic                         cfg_wr;

  dtpw_pkg::dtpw_ctl_t  ctl;
  dtpw_pkg::dtpw_sts_t  sts;
  dtpw_pkg::dtpw_frag_t frag;
  dtpw_pkg::dtpw_res_t  res;
  logic                 res_valid;
  logic                 in_ready;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= '0;
      height_q <= '0;
    end else if (cfg_wr) begin
      case (paddr[2])
        dtpw_pkg::REG_FRAME_WIDTH:  width_q  <= pwdata[dtpw_pkg::FRAME_W-1:0];
        dtpw_pkg::REG_FRAME_HEIGHT: height_q <= pwdata[dtpw_pkg::FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      dtpw_pkg::REG_FRAME_WIDTH:  prdata = 32'(width_q);
      dtpw_pkg::REG_FRAME_HEIGHT: prdata = 32'(height_q);
      default:                    prdata = '0;
    endcase
  end

  assign frag.cmd        = dtpw_pkg::dtpw_op_e'(frag_i.cmd);
  assign frag.pos_x      = frag_i.pos_x;
  assign frag.pos_y      = frag_i.pos_y;
  assign frag.frag_depth = frag_i.frag_depth;
  assign frag.color_in   = frag_i.color_in;
  assign frag_i.ready    = in_ready;

  dtpw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (frag_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  dtpw_dpath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .COLOR_BITS (COLOR_BITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .sts_o          (sts),
    .frame_width_i  (width_q),
    .frame_height_i (height_q),
    .frag_i         (frag),
    .res_ready_i    (res_o.ready),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  assign res_o.valid       = res_valid;
  assign res_o.passed      = res.passed;
  assign res_o.pixel_color = res.pixel_color;
  assign res_o.status      = res.status;

endmodule

/* design/dtpw_ctrl.sv */
// ---------------------------------------------------------------------------
// dtpw_ctrl
// Sequencer: reset sweep, command decode, read-check-write and clear sweeps.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dtpw_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dtpw_pkg::dtpw_sts_t sts_i,
  output dtpw_pkg::dtpw_ctl_t ctl_o
);

  dtpw_pkg::dtpw_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dtpw_pkg::ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      dtpw_pkg::ST_INIT: begin
        if (sts_i.sweep_last) state_d = dtpw_pkg::ST_IDLE;
      end
      dtpw_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (sts_i.op)
            dtpw_pkg::OP_FRAGMENT,
            dtpw_pkg::OP_READ: begin
              state_d = sts_i.in_frame ? dtpw_pkg::ST_READ : dtpw_pkg::ST_PUSH;
            end
            dtpw_pkg::OP_CLEAR_DEPTH: state_d = dtpw_pkg::ST_CLR_DEPTH;
            dtpw_pkg::OP_CLEAR_COLOR: state_d = dtpw_pkg::ST_CLR_COLOR;
            default:                  state_d = dtpw_pkg::ST_IDLE;
          endcase
        end
      end
      dtpw_pkg::ST_READ:  state_d = dtpw_pkg::ST_CHECK;
      dtpw_pkg::ST_CHECK: state_d = dtpw_pkg::ST_PUSH;
      dtpw_pkg::ST_CLR_DEPTH,
      dtpw_pkg::ST_CLR_COLOR: begin
        if (sts_i.sweep_last) state_d = dtpw_pkg::ST_PUSH;
      end
      dtpw_pkg::ST_PUSH: begin
        if (sts_i.out_free) state_d = dtpw_pkg::ST_IDLE;
      end
      default: state_d = dtpw_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    ctl_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      dtpw_pkg::ST_INIT: ctl_o.fill_init = 1'b1;
      dtpw_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        ctl_o.capture = in_valid_i;
      end
      dtpw_pkg::ST_READ:      ctl_o.rd_en      = 1'b1;
      dtpw_pkg::ST_CHECK:     ctl_o.check      = 1'b1;
      dtpw_pkg::ST_CLR_DEPTH: ctl_o.fill_depth = 1'b1;
      dtpw_pkg::ST_CLR_COLOR: ctl_o.fill_color = 1'b1;
      dtpw_pkg::ST_PUSH:      ctl_o.push       = sts_i.out_free;
      default: ;
    endcase
  end

  `DTPW_ASSERT(a_clear_depth_starts,
    (state_q == dtpw_pkg::ST_IDLE && in_valid_i && sts_i.op == dtpw_pkg::OP_CLEAR_DEPTH)
      |=> (state_q == dtpw_pkg::ST_CLR_DEPTH),
    "clear depth transfer did not start a sweep")
  `DTPW_ASSERT(a_sweep_ends,
    ((state_q == dtpw_pkg::ST_CLR_DEPTH || state_q == dtpw_pkg::ST_CLR_COLOR)
      && sts_i.sweep_last) |=> (state_q == dtpw_pkg::ST_PUSH),
    "clear sweep did not end in result push")

endmodule

/* design/dtpw_dpath.sv */
// ---------------------------------------------------------------------------
// dtpw_dpath
// Depth and colour stores, frame check, depth compare and result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dtpw_dpath #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned COLOR_BITS = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  dtpw_pkg::dtpw_ctl_t                    ctl_i,
  output dtpw_pkg::dtpw_sts_t                    sts_o,
  input  logic [dtpw_pkg::FRAME_W-1:0]           frame_width_i,
  input  logic [dtpw_pkg::FRAME_W-1:0]           frame_height_i,
  input  dtpw_pkg::dtpw_frag_t                   frag_i,
  input  logic                                   res_ready_i,
  output logic                                   res_valid_o,
  output dtpw_pkg::dtpw_res_t                    res_o
);

  localparam int unsigned StoreSize = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AddrW     = (StoreSize > 1) ? $clog2(StoreSize) : 1;
  localparam int unsigned DimW      = dtpw_pkg::DIM_W;
  localparam logic [AddrW-1:0] LastIdx = AddrW'(StoreSize - 1);
  localparam logic [DimW-1:0]  MaxW    = DimW'(MAX_WIDTH);
  localparam logic [DimW-1:0]  MaxH    = DimW'(MAX_HEIGHT);

  logic [31:0]           depth_mem [StoreSize];
  logic [COLOR_BITS-1:0] color_mem [StoreSize];

  // Captured command
  dtpw_pkg::dtpw_op_e    op_q;
  logic                  frame_q;
  logic [AddrW-1:0]      addr_q;
  logic signed [31:0]    depth_q;
  logic [COLOR_BITS-1:0] color_q;

  logic [31:0]           drd_q;
  logic [COLOR_BITS-1:0] crd_q;
  logic                  pass_q;
  logic [31:0]           pix_q;

  logic [AddrW-1:0]      sweep_q, sweep_d;
  logic                  out_valid_q, out_valid_d;
  dtpw_pkg::dtpw_res_t   res_q;

  logic [DimW-1:0]       width_ext, height_ext, w_eff, h_eff;
  logic                  in_frame;
  logic [AddrW-1:0]      addr_calc;
  logic                  any_fill, sweep_last, ge, frag_write;

  logic                  d_we, c_we;
  logic [AddrW-1:0]      d_waddr, c_waddr;
  logic [31:0]           d_wdata;
  logic [COLOR_BITS-1:0] c_wdata;

  // Frame check and linear address of the incoming command
  assign width_ext  = DimW'(frame_width_i);
  assign height_ext = DimW'(frame_height_i);
  assign w_eff      = (width_ext > MaxW) ? MaxW : width_ext;
  assign h_eff      = (height_ext > MaxH) ? MaxH : height_ext;
  assign in_frame   = (DimW'(frag_i.pos_x) < w_eff) && (DimW'(frag_i.pos_y) < h_eff);
  assign addr_calc  = AddrW'(frag_i.pos_y) * AddrW'(MAX_WIDTH) + AddrW'(frag_i.pos_x);

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      op_q    <= frag_i.cmd;
      frame_q <= in_frame;
      addr_q  <= addr_calc;
      depth_q <= frag_i.frag_depth;
      color_q <= COLOR_BITS'(frag_i.color_in);
    end
  end

  // Depth test, greater or equal on signed Q16.16
  assign ge         = depth_q >= $signed(drd_q);
  assign frag_write = ctl_i.check && (op_q == dtpw_pkg::OP_FRAGMENT) && ge;

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      pass_q <= 1'b0;
      pix_q  <= '0;
    end else if (ctl_i.check) begin
      pass_q <= (op_q == dtpw_pkg::OP_FRAGMENT) && ge;
      pix_q  <= (op_q == dtpw_pkg::OP_READ) ? 32'(crd_q) : 32'd0;
    end
  end

  // Sweep counter shared by the reset fill and both clears
  assign any_fill   = ctl_i.fill_depth || ctl_i.fill_color || ctl_i.fill_init;
  assign sweep_last = (sweep_q == LastIdx);

  always_comb begin
    sweep_d = sweep_q;
    if (any_fill) begin
      sweep_d = sweep_last ? '0 : sweep_q + AddrW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else begin
      sweep_q <= sweep_d;
    end
  end

  // Store write ports
  assign d_we    = ctl_i.fill_depth || ctl_i.fill_init || frag_write;
  assign d_waddr = (ctl_i.fill_depth || ctl_i.fill_init) ? sweep_q : addr_q;
  assign d_wdata = (ctl_i.fill_depth || ctl_i.fill_init) ? dtpw_pkg::DEPTH_NEG_INF
                                                         : depth_q;
  assign c_we    = ctl_i.fill_color || ctl_i.fill_init || frag_write;
  assign c_waddr = (ctl_i.fill_color || ctl_i.fill_init) ? sweep_q : addr_q;
  assign c_wdata = ctl_i.fill_init ? '0 : color_q;

  always_ff @(posedge clk_i) begin
    if (d_we) depth_mem[d_waddr] <= d_wdata;
    if (ctl_i.rd_en) drd_q <= depth_mem[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (c_we) color_mem[c_waddr] <= c_wdata;
    if (ctl_i.rd_en) crd_q <= color_mem[addr_q];
  end

  // Output register: hold the result until the transfer completes
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_i.push) begin
      out_valid_d = 1'b1;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      res_q.passed      <= pass_q;
      res_q.pixel_color <= pix_q;
      res_q.status      <= ((op_q == dtpw_pkg::OP_FRAGMENT) || (op_q == dtpw_pkg::OP_READ))
                           && !frame_q;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

  assign sts_o.op         = frag_i.cmd;
  assign sts_o.in_frame   = in_frame;
  assign sts_o.sweep_last = sweep_last;
  assign sts_o.out_free   = !out_valid_q || res_ready_i;

  `DTPW_NEVER(a_fill_vs_check, ctl_i.check && any_fill,
    "store sweep overlaps a depth check")
  `DTPW_ASSERT(a_push_free, ctl_i.push |-> (!out_valid_q || res_ready_i),
    "result pushed over an unsent result")
  `DTPW_ASSERT(a_pass_frag_only,
    (ctl_i.check && op_q != dtpw_pkg::OP_FRAGMENT) |=> !pass_q,
    "pass flagged for a command that is not a fragment")

endmodule

/* tb/sv/depth_test_pixel_write_core_test.sv */
// ---------------------------------------------------------------------------
// depth_test_pixel_write_core_test
// Self-checking bench for the z-buffer back end. A directed table covers
// empty and saturated frames, frame edges, depth extremes and both clears.
// Random phases follow, each with its own frame size. A local model of both
// stores predicts results not typed in the table; all are checked in order.
// ---------------------------------------------------------------------------
module depth_test_pixel_write_core_test;

  localparam int FRAME_MAX_W = 256;
  localparam int FRAME_MAX_H = 256;
  localparam int STORE_SIZE  = FRAME_MAX_W * FRAME_MAX_H;
  localparam int RANDOM_ITEMS = 1600;
  localparam int CLEAR_BUDGET = 4;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 16;
  localparam longint LIMIT_TIME = 64'd60_000_000;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_RANDOM,
    SINK_PATTERN,
    SINK_STARVED
  } sink_mode_e;

  typedef struct {
    logic [8:0]           w;
    logic [8:0]           h;
    dtpw_pkg::dtpw_frag_t f;
    bit                   typed;
    dtpw_pkg::dtpw_res_t  res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [dtpw_pkg::APB_ADDR_W-1:0] paddr;
  logic [31:0]                     pwdata;
  logic [31:0]                     prdata;
  logic                            pready;

  dtpw_in_if  frag_bus ();
  dtpw_out_if res_bus ();

  depth_test_pixel_write_core #(
    .MAX_WIDTH  (FRAME_MAX_W),
    .MAX_HEIGHT (FRAME_MAX_H),
    .COLOR_BITS (32)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .frag_i  (frag_bus),
    .res_o   (res_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Local copy of the stores and the frame registers
  logic [31:0] zdepth [0:STORE_SIZE-1];
  logic [31:0] zcolor [0:STORE_SIZE-1];
  logic [8:0]  cfg_width;
  logic [8:0]  cfg_height;

  dtpw_pkg::dtpw_res_t pixel_expect [$];
  stim_row_t           dir_rows [$];

  int errors;
  int results_checked;
  int n_written, n_hidden, n_rejected, n_reads, n_clears;
  int frames_set;
  int holds_done;
  int holds_asked;
  int clears_left = CLEAR_BUDGET;

  task automatic report_mismatch(input string what);
    errors++;
    $display("ERROR at %0t: %s", $time, what);
  endtask

  function automatic dtpw_pkg::dtpw_res_t predict_pixel(input dtpw_pkg::dtpw_frag_t f);
    dtpw_pkg::dtpw_res_t r;
    int ew;
    int eh;
    int slot;
    bit hit;
    r = '0;
    ew = (cfg_width > FRAME_MAX_W) ? FRAME_MAX_W : int'(cfg_width);
    eh = (cfg_height > FRAME_MAX_H) ? FRAME_MAX_H : int'(cfg_height);
    hit = (ew != 0) && (eh != 0) && (int'(f.pos_x) < ew) && (int'(f.pos_y) < eh);
    slot = int'(f.pos_y) * FRAME_MAX_W + int'(f.pos_x);
    case (f.cmd)
      dtpw_pkg::OP_FRAGMENT: begin
        if (!hit) begin
          r.status = 1'b1;
        end else if ($signed(f.frag_depth) >= $signed(zdepth[slot])) begin
          zdepth[slot] = f.frag_depth;
          zcolor[slot] = f.color_in;
          r.passed = 1'b1;
        end
      end
      dtpw_pkg::OP_CLEAR_DEPTH: begin
        foreach (zdepth[i]) zdepth[i] = dtpw_pkg::DEPTH_NEG_INF;
      end
      dtpw_pkg::OP_CLEAR_COLOR: begin
        foreach (zcolor[i]) zcolor[i] = f.color_in;
      end
      default: begin
        if (!hit) r.status = 1'b1;
        else r.pixel_color = zcolor[slot];
      end
    endcase
    return r;
  endfunction

  // Offer one command, wait for its transfer, then log what it must return
  task automatic offer(input dtpw_pkg::dtpw_frag_t f, input bit typed,
                       input dtpw_pkg::dtpw_res_t typed_res);
    dtpw_pkg::dtpw_res_t r;
    @(negedge clk_i);
    frag_bus.valid      <= 1'b1;
    frag_bus.cmd        <= f.cmd;
    frag_bus.pos_x      <= f.pos_x;
    frag_bus.pos_y      <= f.pos_y;
    frag_bus.frag_depth <= f.frag_depth;
    frag_bus.color_in   <= f.color_in;
    do @(posedge clk_i); while (!frag_bus.ready);
    r = predict_pixel(f);
    pixel_expect.push_back(typed ? typed_res : r);
    if (r.status) n_rejected++;
    else if (f.cmd == dtpw_pkg::OP_FRAGMENT) begin
      if (r.passed) n_written++;
      else n_hidden++;
    end else if (f.cmd == dtpw_pkg::OP_READ) n_reads++;
    else n_clears++;
  endtask

  // Drop valid and hold until every result has come back
  task automatic drain();
    @(negedge clk_i);
    frag_bus.valid <= 1'b0;
    while (pixel_expect.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_xfer(input logic wr, input logic [dtpw_pkg::APB_ADDR_W-1:0] addr,
                          input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_frame(input logic [8:0] w, input logic [8:0] h);
    logic [31:0] back;
    apb_xfer(1'b1, {dtpw_pkg::REG_FRAME_WIDTH, 2'b00}, {23'($urandom), w}, back);
    apb_xfer(1'b1, {dtpw_pkg::REG_FRAME_HEIGHT, 2'b00}, {23'($urandom), h}, back);
    cfg_width  = w;
    cfg_height = h;
    frames_set++;
    apb_xfer(1'b0, {dtpw_pkg::REG_FRAME_WIDTH, 2'b00}, 32'd0, back);
    if (back !== {23'd0, w})
      report_mismatch($sformatf("frame_width read %0h, wrote %0h", back, w));
    apb_xfer(1'b0, {dtpw_pkg::REG_FRAME_HEIGHT, 2'b00}, 32'd0, back);
    if (back !== {23'd0, h})
      report_mismatch($sformatf("frame_height read %0h, wrote %0h", back, h));
  endtask

  // Columns: frame w, h | cmd, x, y, depth, colour | typed?, passed, colour out, status
  function automatic void add_row(input logic [8:0] w, input logic [8:0] h,
                                  input dtpw_pkg::dtpw_op_e op, input logic [7:0] x,
                                  input logic [7:0] y, input logic [31:0] depth,
                                  input logic [31:0] color, input bit typed,
                                  input logic passed, input logic [31:0] pix,
                                  input logic status);
    stim_row_t row;
    row.w              = w;
    row.h              = h;
    row.f.cmd          = op;
    row.f.pos_x        = x;
    row.f.pos_y        = y;
    row.f.frag_depth   = depth;
    row.f.color_in     = color;
    row.typed          = typed;
    row.res.passed     = passed;
    row.res.pixel_color = pix;
    row.res.status     = status;
    dir_rows.push_back(row);
  endfunction

  // Mostly a small hot corner so depth tests hit written pixels, plus edges
  function automatic logic [7:0] pick_pos(input int span);
    int r;
    r = $urandom_range(0, 9);
    if (span == 0 || r == 9) return 8'($urandom_range(0, 255));
    if (r < 5) return 8'($urandom_range(0, ((span < 6) ? span : 6) - 1));
    if (r < 8) return 8'($urandom_range(0, span - 1));
    return (span < 256) ? 8'(span) : 8'd255;
  endfunction

  function automatic dtpw_pkg::dtpw_frag_t rand_item();
    dtpw_pkg::dtpw_frag_t f;
    int ew;
    int eh;
    int pick;
    ew = (cfg_width > FRAME_MAX_W) ? FRAME_MAX_W : int'(cfg_width);
    eh = (cfg_height > FRAME_MAX_H) ? FRAME_MAX_H : int'(cfg_height);
    f.pos_x    = pick_pos(ew);
    f.pos_y    = pick_pos(eh);
    f.color_in = $urandom;
    case ($urandom_range(0, 5))
      0:       f.frag_depth = dtpw_pkg::DEPTH_NEG_INF;
      1:       f.frag_depth = 32'h7FFF_FFFF;
      2:       f.frag_depth = 32'($urandom_range(0, 15)) - 32'd8;
      3:       f.frag_depth = 32'($urandom_range(0, 32'h1_FFFF)) - 32'h1_0000;
      default: f.frag_depth = $urandom;
    endcase
    pick = $urandom_range(0, 399);
    if (pick < 2 && clears_left > 0) begin
      f.cmd = (pick == 0) ? dtpw_pkg::OP_CLEAR_DEPTH : dtpw_pkg::OP_CLEAR_COLOR;
      clears_left--;
    end else if (pick < 280) begin
      f.cmd = dtpw_pkg::OP_FRAGMENT;
    end else begin
      f.cmd = dtpw_pkg::OP_READ;
    end
    return f;
  endfunction

  function automatic logic [8:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return 9'd0;
      1:       return 9'd1;
      2:       return 9'd255;
      3:       return 9'd256;
      4:       return 9'd511;
      5:       return 9'($urandom_range(257, 511));
      default: return 9'($urandom_range(1, 256));
    endcase
  endfunction

  // Result check, in order of the command transfers
  always @(posedge clk_i) begin
    dtpw_pkg::dtpw_res_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (pixel_expect.size() == 0) begin
        report_mismatch("result transfer with no command outstanding");
      end else begin
        want = pixel_expect.pop_front();
        results_checked++;
        if (res_bus.passed !== want.passed)
          report_mismatch($sformatf("passed %0b, want %0b", res_bus.passed, want.passed));
        if (res_bus.pixel_color !== want.pixel_color)
          report_mismatch($sformatf("pixel_color %08h, want %08h",
                                    res_bus.pixel_color, want.pixel_color));
        if (res_bus.status !== want.status)
          report_mismatch($sformatf("status %0b, want %0b", res_bus.status, want.status));
      end
    end
  end

  // Result side: stretches of open, random, patterned and starved ready, and long holds on request
  initial begin : result_sink
    sink_mode_e mode;
    int span;
    int k;
    res_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (holds_asked > holds_done) begin
        for (k = 0; k < HOLD_CYCLES; k++) begin
          @(negedge clk_i);
          res_bus.ready <= 1'b0;
        end
        holds_done++;
      end
      mode = sink_mode_e'($urandom_range(0, 3));
      span = $urandom_range(8, 120);
      for (k = 0; k < span; k++) begin
        @(negedge clk_i);
        case (mode)
          SINK_OPEN:    res_bus.ready <= 1'b1;
          SINK_RANDOM:  res_bus.ready <= ($urandom_range(0, 2) != 0);
          SINK_PATTERN: res_bus.ready <= k[2];
          default:      res_bus.ready <= ($urandom_range(0, 5) == 0);
        endcase
      end
    end
  end

  initial begin : run_limit
    #(LIMIT_TIME);
    $display("Timeout with %0d results outstanding", pixel_expect.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int phase;
    int n;
    int k;
    int burst_left;
    int random_sent;
    bit gapless;

    rst_ni              = 1'b0;
    frag_bus.valid      = 1'b0;
    frag_bus.cmd        = dtpw_pkg::OP_FRAGMENT;
    frag_bus.pos_x      = '0;
    frag_bus.pos_y      = '0;
    frag_bus.frag_depth = '0;
    frag_bus.color_in   = '0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    cfg_width           = '0;
    cfg_height          = '0;
    foreach (zdepth[i]) zdepth[i] = dtpw_pkg::DEPTH_NEG_INF;
    foreach (zcolor[i]) zcolor[i] = '0;

    // empty frame in either direction
    add_row(0, 0, dtpw_pkg::OP_FRAGMENT, 0, 0, 32'h0, 32'hDEAD_BEEF, 1, 0, 0, 1);
    add_row(0, 0, dtpw_pkg::OP_READ, 255, 255, 32'h0, 32'h0, 1, 0, 0, 1);
    add_row(0, 0, dtpw_pkg::OP_CLEAR_DEPTH, 0, 0, 32'h0, 32'h0, 1, 0, 0, 0);
    add_row(256, 0, dtpw_pkg::OP_FRAGMENT, 5, 5, 32'h0, 32'h1, 1, 0, 0, 1);
    add_row(0, 256, dtpw_pkg::OP_READ, 5, 5, 32'h0, 32'h0, 1, 0, 0, 1);
    // oversized registers saturate at the store size
    add_row(511, 300, dtpw_pkg::OP_READ, 255, 255, 32'h0, 32'h0, 1, 0, 0, 0);
    add_row(511, 300, dtpw_pkg::OP_FRAGMENT, 255, 255, dtpw_pkg::DEPTH_NEG_INF,
            32'hFFFF_FFFF, 1, 1, 0, 0);
    add_row(511, 300, dtpw_pkg::OP_READ, 255, 255, 32'h0, 32'h0, 1, 0, 32'hFFFF_FFFF, 0);
    add_row(511, 300, dtpw_pkg::OP_FRAGMENT, 255, 255, dtpw_pkg::DEPTH_NEG_INF,
            32'h0, 1, 1, 0, 0);
    add_row(511, 300, dtpw_pkg::OP_FRAGMENT, 0, 0, 32'h7FFF_FFFF, 32'hA5A5_A5A5, 1, 1, 0, 0);
    add_row(511, 300, dtpw_pkg::OP_FRAGMENT, 0, 0, 32'h7FFF_FFFE, 32'h0, 1, 0, 0, 0);
    add_row(511, 300, dtpw_pkg::OP_FRAGMENT, 0, 0, 32'h7FFF_FFFF, 32'h5A5A_5A5A, 1, 1, 0, 0);
    add_row(511, 300, dtpw_pkg::OP_READ, 0, 0, 32'h0, 32'h0, 1, 0, 32'h5A5A_5A5A, 0);
    // signed compare around zero
    add_row(511, 300, dtpw_pkg::OP_FRAGMENT, 128, 1, 32'hFFFF_FFFF, 32'h0F0F_0F0F,
            0, 0, 0, 0);
    add_row(511, 300, dtpw_pkg::OP_FRAGMENT, 128, 1, 32'h0, 32'hF0F0_F0F0, 0, 0, 0, 0);
    add_row(511, 300, dtpw_pkg::OP_FRAGMENT, 128, 1, 32'hFFFF_0000, 32'h0, 0, 0, 0, 0);
    add_row(511, 300, dtpw_pkg::OP_READ, 128, 1, 32'h0, 32'h0, 0, 0, 0, 0);
    // frame edges
    add_row(16, 8, dtpw_pkg::OP_FRAGMENT, 16, 0, 32'h0, 32'h0, 1, 0, 0, 1);
    add_row(16, 8, dtpw_pkg::OP_FRAGMENT, 15, 8, 32'h0, 32'h0, 1, 0, 0, 1);
    add_row(16, 8, dtpw_pkg::OP_FRAGMENT, 15, 7, 32'h0001_0000, 32'h1122_3344, 0, 0, 0, 0);
    add_row(16, 8, dtpw_pkg::OP_READ, 255, 255, 32'h0, 32'h0, 1, 0, 0, 1);
    add_row(16, 8, dtpw_pkg::OP_CLEAR_COLOR, 0, 0, 32'h0, 32'h1234_5678, 1, 0, 0, 0);
    add_row(16, 8, dtpw_pkg::OP_READ, 15, 7, 32'h0, 32'h0, 1, 0, 32'h1234_5678, 0);
    add_row(1, 1, dtpw_pkg::OP_FRAGMENT, 0, 0, dtpw_pkg::DEPTH_NEG_INF, 32'h0, 0, 0, 0, 0);
    add_row(1, 1, dtpw_pkg::OP_READ, 0, 1, 32'h0, 32'h0, 1, 0, 0, 1);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].w != cfg_width || dir_rows[i].h != cfg_height) begin
        drain();
        set_frame(dir_rows[i].w, dir_rows[i].h);
      end
      offer(dir_rows[i].f, dir_rows[i].typed, dir_rows[i].res);
    end

    phase       = 0;
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      drain();
      set_frame(pick_size(), pick_size());
      n = (phase == 1) ? 300 : $urandom_range(40, 220);
      // phase 1: long result stall while commands keep coming; some others also gapless
      gapless = (phase == 1) || ($urandom_range(0, 3) == 0);
      if (phase == 1) holds_asked++;
      burst_left = 0;
      for (k = 0; k < n && random_sent < RANDOM_ITEMS; k++) begin
        if (burst_left == 0) begin
          if (!gapless) begin
            repeat ($urandom_range(1, 8)) begin
              @(negedge clk_i);
              frag_bus.valid <= 1'b0;
            end
          end
          burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        offer(rand_item(), 1'b0, '0);
        random_sent++;
        if ($urandom_range(0, 99) == 0) drain();
      end
      phase++;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d frame settings: %0d fragments written, %0d hidden by depth, %0d rejected",
             frames_set, n_written, n_hidden, n_rejected);
    $display("Also %0d colour reads, %0d clears, %0d long stalls; %0d results, %0d mismatches",
             n_reads, n_clears, holds_done, results_checked, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
